// ===== hw/rtl/ecat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecat_pkg
// Shared types and codes for the eased color and alpha tween block.
// ----------------------------------------------------------------------------
package ecat_pkg;

    localparam int NUM_CH     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ACT_IDLE_DONE = 2'd0,
        ACT_NO_CHANGE = 2'd1,
        ACT_INSTANT   = 2'd2,
        ACT_BLEND     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CURVE_LINEAR = 2'd0,
        CURVE_EASE   = 2'd1,
        CURVE_IN     = 2'd2,
        CURVE_OUT    = 2'd3
    } curve_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_RED   = 3'd0,
        REG_TARGET_GREEN = 3'd1,
        REG_TARGET_BLUE  = 3'd2,
        REG_TARGET_ALPHA = 3'd3,
        REG_DURATION_MS  = 3'd4,
        REG_CURVE        = 3'd5,
        REG_CHANNEL_MASK = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic        restart;
        logic [15:0] elapsed_ms;
        logic [7:0]  cur_red;
        logic [7:0]  cur_green;
        logic [7:0]  cur_blue;
        logic [7:0]  cur_alpha;
    } item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        action_t    action;
        logic       finished;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/eased_color_alpha_tween.sv =====
`default_nettype none
// Timing: a finished, unchanged or instant frame passes through S_FINISH to
//   the result register; an interpolated frame passes S_DIV, S_PHASE, S_LOOK,
//   S_MUL for each channel and S_FINISH, the divider yielding one fraction bit
//   per cycle, or none when elapsed reaches twice the duration.
// Frames: the block takes a new frame only in S_IDLE, one frame at a time, and
//   a stalled result holds it in S_FINISH.
// Reset: control state and configuration registers clear at once; there is no
//   clearing pass and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// eased_color_alpha_tween
// Per-frame color and alpha tween with linear and cosine easing curves,
// run by a small sequencer around a serial divider and one multiplier.
// ----------------------------------------------------------------------------
module eased_color_alpha_tween #(
    parameter int COS_TABLE_DEPTH = 256,
    parameter int FRAC_BITS       = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  ecat_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output ecat_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [ecat_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ecat_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import ecat_pkg::*;

    localparam int TW    = FRAC_BITS + 2;
    localparam int UW    = FRAC_BITS + 3;
    localparam int SW    = FRAC_BITS + 4;
    localparam int PW    = SW + 9;
    localparam int SUMW  = SW + 10;
    localparam int AW    = $clog2(COS_TABLE_DEPTH + 1);
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int EPS_I = (ONE_I + 50) / 100;

    localparam logic [TW-1:0]        ONE_T   = TW'(ONE_I);
    localparam logic signed [SW-1:0] ONE_S   = SW'(ONE_I);
    localparam logic signed [SW-1:0] EPS_S   = SW'(EPS_I);
    localparam logic [AW-1:0]        DEPTH_A = AW'(COS_TABLE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIV    = 6'b000010,
        S_PHASE  = 6'b000100,
        S_LOOK   = 6'b001000,
        S_MUL    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]  tgt_reg [NUM_CH];
    logic [15:0] duration_reg;
    curve_t      curve_reg;
    logic [3:0]  mask_reg;

    logic        captured_reg, captured_next;
    logic        done_reg, done_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  ch_reg, ch_next;
    action_t     act_reg, act_next;

    logic [7:0]              res_reg [NUM_CH];
    logic [7:0]              res_next [NUM_CH];
    logic [7:0]              start_reg [NUM_CH];
    logic [7:0]              start_next [NUM_CH];
    logic [TW-1:0]           t_reg, t_next;
    logic                    neg_reg, neg_next;
    logic signed [SW-1:0]    s_reg, s_next;
    result_t                 out_reg, out_next;

    logic [7:0] cur_val [NUM_CH];
    logic       accept;
    logic       done_eff;
    logic       cap_eff;
    logic       equal;

    logic          div_start;
    logic          div_done;
    logic [TW-1:0] div_q;

    logic [UW-1:0]           phase;
    logic [1:0]              quad;
    logic [FRAC_BITS+AW-1:0] scaled;
    logic [AW-1:0]           idx;
    logic [AW-1:0]           rom_addr;
    logic [FRAC_BITS:0]      rom_data;
    logic                    phase_neg;

    logic signed [SW-1:0]    cos_mag;
    logic signed [SW-1:0]    cos_s;
    logic signed [SW-1:0]    shaped;
    logic                    s_over;

    logic [7:0]              st_sel;
    logic [7:0]              tg_sel;
    logic signed [8:0]       diff;
    logic signed [PW-1:0]    prod;
    logic signed [SUMW-1:0]  base;
    logic signed [SUMW-1:0]  sum;
    logic [7:0]              blend;

    assign cur_val[0] = item.cur_red;
    assign cur_val[1] = item.cur_green;
    assign cur_val[2] = item.cur_blue;
    assign cur_val[3] = item.cur_alpha;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);

    ecat_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (item.elapsed_ms),
        .divisor  (duration_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    ecat_cos_rom #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .FRAC_BITS       (FRAC_BITS)
    ) u_cos_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // Cosine phase in quarter waves, split into quadrant and table index.
    always_comb
    begin
        unique case (curve_reg)
            CURVE_EASE:
                phase = {t_reg, 1'b0};
            CURVE_IN:
                phase = (t_reg > ONE_T) ? UW'(t_reg - ONE_T) : UW'(ONE_T - t_reg);
            CURVE_LINEAR, CURVE_OUT:
                phase = UW'(t_reg);
            default:
                phase = UW'(t_reg);
        endcase
        quad      = phase[FRAC_BITS+1:FRAC_BITS];
        scaled    = (FRAC_BITS+AW)'(phase[FRAC_BITS-1:0])
                    * (FRAC_BITS+AW)'(COS_TABLE_DEPTH);
        idx       = scaled[FRAC_BITS+AW-1:FRAC_BITS];
        rom_addr  = quad[0] ? (DEPTH_A - idx) : idx;
        phase_neg = (quad == 2'd1) || (quad == 2'd2);
    end

    // Curve shaping from the signed cosine.
    always_comb
    begin
        cos_mag = SW'({1'b0, rom_data});
        cos_s   = neg_reg ? -cos_mag : cos_mag;
        unique case (curve_reg)
            CURVE_LINEAR: shaped = SW'({1'b0, t_reg});
            CURVE_EASE:   shaped = ((ONE_S - cos_s) >>> 1) + EPS_S;
            CURVE_IN:     shaped = cos_s + EPS_S;
            CURVE_OUT:    shaped = ONE_S - cos_s + EPS_S;
            default:      shaped = SW'({1'b0, t_reg});
        endcase
        s_over = shaped > ONE_S;
    end

    // One channel blend per cycle: start + s * (target - start), floored.
    always_comb
    begin
        st_sel = start_reg[ch_reg];
        tg_sel = tgt_reg[ch_reg];
        diff   = $signed({1'b0, tg_sel}) - $signed({1'b0, st_sel});
        prod   = PW'(s_reg) * PW'(diff);
        base   = SUMW'({st_sel, {FRAC_BITS{1'b0}}});
        sum    = base + SUMW'(prod);
        blend  = sum[SUMW-1] ? 8'd0 : sum[FRAC_BITS+7:FRAC_BITS];
    end

    always_comb
    begin
        done_eff = done_reg && !item.restart;
        cap_eff  = captured_reg && !item.restart;
        equal    = 1'b1;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (mask_reg[c] && (cur_val[c] != tgt_reg[c]))
                equal = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        captured_next  = captured_reg;
        done_next      = done_reg;
        ch_next        = ch_reg;
        act_next       = act_reg;
        t_next         = t_reg;
        neg_next       = neg_reg;
        s_next         = s_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        div_start      = 1'b0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            res_next[c]   = res_reg[c];
            start_next[c] = start_reg[c];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                        res_next[c] = cur_val[c];
                    captured_next = cap_eff;
                    done_next     = done_eff;
                    priority if (done_eff)
                    begin
                        act_next   = ACT_IDLE_DONE;
                        state_next = S_FINISH;
                    end
                    else if (equal)
                    begin
                        done_next  = 1'b1;
                        act_next   = ACT_NO_CHANGE;
                        state_next = S_FINISH;
                    end
                    else if (duration_reg == 16'd0)
                    begin
                        for (int c = 0; c < NUM_CH; c++)
                        begin
                            if (mask_reg[c])
                                res_next[c] = tgt_reg[c];
                        end
                        done_next  = 1'b1;
                        act_next   = ACT_INSTANT;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        if (!cap_eff)
                        begin
                            for (int c = 0; c < NUM_CH; c++)
                                start_next[c] = cur_val[c];
                        end
                        captured_next = 1'b1;
                        act_next      = ACT_BLEND;
                        div_start     = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    t_next     = div_q;
                    state_next = S_PHASE;
                end
            end
            S_PHASE:
            begin
                // The table address is presented here; its data is read next cycle.
                neg_next   = phase_neg;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                s_next = s_over ? ONE_S : shaped;
                if (s_over)
                    done_next = 1'b1;
                ch_next    = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mask_reg[ch_reg])
                    res_next[ch_reg] = blend;
                ch_next = ch_reg + 2'd1;
                if (ch_reg == 2'd3)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.out_red   = res_reg[0];
                    out_next.out_green = res_reg[1];
                    out_next.out_blue  = res_reg[2];
                    out_next.out_alpha = res_reg[3];
                    out_next.action    = act_reg;
                    out_next.finished  = done_reg;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg[0]   <= 8'd0;
            tgt_reg[1]   <= 8'd0;
            tgt_reg[2]   <= 8'd0;
            tgt_reg[3]   <= 8'd255;
            duration_reg <= 16'd0;
            curve_reg    <= CURVE_LINEAR;
            mask_reg     <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_RED:   tgt_reg[0]   <= cfg_data[7:0];
                REG_TARGET_GREEN: tgt_reg[1]   <= cfg_data[7:0];
                REG_TARGET_BLUE:  tgt_reg[2]   <= cfg_data[7:0];
                REG_TARGET_ALPHA: tgt_reg[3]   <= cfg_data[7:0];
                REG_DURATION_MS:  duration_reg <= cfg_data;
                REG_CURVE:        curve_reg    <= curve_t'(cfg_data[1:0]);
                REG_CHANNEL_MASK: mask_reg     <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            captured_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ch_reg        <= 2'd0;
            act_reg       <= ACT_IDLE_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            captured_reg  <= captured_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
            ch_reg        <= ch_next;
            act_reg       <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            res_reg[c]   <= res_next[c];
            start_reg[c] <= start_next[c];
        end
        t_reg   <= t_next;
        neg_reg <= neg_next;
        s_reg   <= s_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ecat_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecat_div
// Restoring divider for the tween fraction elapsed / duration, one quotient
// bit per cycle through a single 17-bit subtract and compare.
// ----------------------------------------------------------------------------
module ecat_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [15:0]          dividend,
    input  logic [15:0]          divisor,
    output logic                 done,
    output logic [FRAC_BITS+1:0] quotient
);

    localparam int QW   = FRAC_BITS + 2;
    localparam int CNTW = $clog2(FRAC_BITS + 1);

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [15:0]     rem_reg, rem_next;
    logic [15:0]     dvs_reg, dvs_next;
    logic [QW-1:0]   quo_reg, quo_next;

    logic [16:0] rem_dbl;
    logic [16:0] rem_sub;
    logic        step_ge;
    logic        sat;
    logic        int_ge;

    always_comb
    begin
        rem_dbl = {rem_reg, 1'b0};
        step_ge = rem_dbl >= {1'b0, dvs_reg};
        rem_sub = rem_dbl - {1'b0, dvs_reg};
        // The fraction is capped at 2.0, so elapsed at or above twice the
        // duration needs no iteration at all.
        sat     = {1'b0, dividend} >= {divisor, 1'b0};
        int_ge  = dividend >= divisor;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            dvs_next  = divisor;
            if (sat)
            begin
                quo_next = QW'(1) << (FRAC_BITS + 1);
                cnt_next = '0;
            end
            else
            begin
                rem_next = int_ge ? (dividend - divisor) : dividend;
                quo_next = QW'(int_ge);
                cnt_next = CNTW'(FRAC_BITS);
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = step_ge ? rem_sub[15:0] : rem_dbl[15:0];
                quo_next = {quo_reg[QW-2:0], step_ge};
                cnt_next = cnt_reg - CNTW'(1);
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ecat_cos_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecat_cos_rom
// Quarter-wave cosine table with a registered read port. Entry k holds
// cos(k/DEPTH * pi/2) in unsigned fixed point, built at elaboration.
// ----------------------------------------------------------------------------
module ecat_cos_rom #(
    parameter int COS_TABLE_DEPTH = 256,
    parameter int FRAC_BITS       = 16
) (
    input  logic                               clk,
    input  logic [$clog2(COS_TABLE_DEPTH+1)-1:0] addr,
    output logic [FRAC_BITS:0]                 data
);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_L       = longint'(1) << FRAC_BITS;

    typedef logic [FRAC_BITS:0] cos_tab_t [0:COS_TABLE_DEPTH];

    // Long division by shift and subtract, used only while the table is built.
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Thirteen-term Taylor series in Q30, rounded half up to the table format.
    function automatic cos_tab_t build_tab();
        cos_tab_t        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned dvs;
        longint          sum;
        longint          v;
        int              k;
        int              n;
        for (k = 0; k <= COS_TABLE_DEPTH; k++)
        begin
            x    = udiv(HALF_PI_Q30 * 64'(k), 64'(COS_TABLE_DEPTH));
            x2   = (x * x) >> 30;
            term = longint'(1) << 30;
            sum  = longint'(term);
            for (n = 1; n <= 12; n++)
            begin
                dvs  = 64'((2 * n - 1) * (2 * n));
                term = udiv((term * x2) >> 30, dvs);
                if ((n & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            v = sum;
            if (v < 0)
                v = 0;
            v = (v + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
            if (v > ONE_L)
                v = ONE_L;
            tab[k] = v[FRAC_BITS:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_tab();

    logic [FRAC_BITS:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= COS_TAB[addr];
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ecat_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ecat_checker
// Port-level checks for the tween block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ecat_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_stall,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire ecat_pkg::result_t result
);

    import ecat_pkg::*;

    // A stalled result keeps its value until its transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Only an interpolated write can leave the transform unfinished.
    a_finished_rule: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action != ACT_BLEND) |-> result.finished)
        else $error("non-interpolated result without finished flag");

    // One frame at a time: the block is busy right after a transfer in.
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("second frame taken while the first is in work");

    // A result never appears in the cycle right after a frame is taken.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> !$rose(result_valid))
        else $error("result raised too early");

endmodule

bind eased_color_alpha_tween ecat_checker u_ecat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire
